>>> rtl/core/rgbs_pkg.sv
// Shared types, constants and helper functions for the RGB LED animation sequencer.
package rgbs_pkg;

   localparam int DT_W   = 20;
   localparam int CFG_W  = 24;
   localparam int ACC_W  = 25;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_PERIOD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HUE_SWEEP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STROBE_HALF  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_SWEEP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_STEP   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_RANDOM = 3'd5;

   localparam logic [CFG_W-1:0] RST_SHIFT_PERIOD = 24'd2000000;
   localparam logic [CFG_W-1:0] RST_HUE_SWEEP    = 24'd500000;
   localparam logic [CFG_W-1:0] RST_STROBE_HALF  = 24'd30000;
   localparam logic [CFG_W-1:0] RST_FADE_SWEEP   = 24'd500000;
   localparam logic [CFG_W-1:0] RST_COLOR_STEP   = 24'd100000;

   localparam logic [1:0] EFF_HUE    = 2'd0;
   localparam logic [1:0] EFF_STROBE = 2'd1;
   localparam logic [1:0] EFF_FADE   = 2'd2;
   localparam logic [1:0] EFF_TABLE  = 2'd3;

   localparam logic [15:0] LFSR_SEED = 16'hACE1;

   typedef struct packed {
      logic take;       // latch dt of an accepted transaction
      logic div_start;  // launch the ramp divider
      logic apply;      // commit the frame step
   } cmd_type;

   typedef struct packed {
      logic ramp;       // active effect needs a ramp increment
      logic div_done;
   } status_type;

   typedef struct packed {
      logic             hit;
      logic [ACC_W-1:0] acc;
   } timer_type;

   // Add elapsed time, subtract one period on crossing, saturate.
   function automatic timer_type timer_step(logic [ACC_W-1:0] acc, logic [DT_W-1:0] dt,
                                            logic [CFG_W-1:0] period);
      logic [ACC_W:0] sum;
      timer_type      t;
      sum = {1'b0, acc} + (ACC_W+1)'(dt);
      t.hit = (sum >= (ACC_W+1)'(period));
      if (t.hit) begin
         sum = sum - (ACC_W+1)'(period);
      end
      t.acc = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
      return t;
   endfunction

   // Seven-entry palette, indexed modulo seven; returns {r, g, b}.
   function automatic logic [23:0] palette(logic [3:0] idx);
      logic [3:0]  m;
      logic [23:0] c;
      if (idx >= 4'd14) begin
         m = idx - 4'd14;
      end else if (idx >= 4'd7) begin
         m = idx - 4'd7;
      end else begin
         m = idx;
      end
      unique case (m[2:0])
         3'd0: c = 24'hFFFFFF;
         3'd1: c = 24'hFF0000;
         3'd2: c = 24'h00FF00;
         3'd3: c = 24'h0000FF;
         3'd4: c = 24'hFFFF00;
         3'd5: c = 24'h00FFFF;
         3'd6: c = 24'hFF00FF;
         default: c = 24'hFFFFFF;
      endcase
      return c;
   endfunction

   function automatic logic [15:0] lfsr_advance(logic [15:0] w);
      logic [15:0] l;
      logic        fb;
      l = (w == 16'd0) ? LFSR_SEED : w;
      fb = l[0] ^ l[2] ^ l[3] ^ l[5];
      return {fb, l[15:1]};
   endfunction

endpackage

>>> rtl/core/rgb_led_animation_sequencer.sv
// Top level of the RGB LED animation sequencer.
//  channel  | ports                                   | role
//  req      | req_valid, req_ready, req_dt_us         | frame tick with elapsed us
//  rsp      | rsp_valid, rsp_ready, rsp_*_level,      | levels and active effect
//           | rsp_effect_now                          |
//  csr      | csr_valid, csr_ready, csr_index,        | register write, always ready
//           | csr_wdata                               |
// Hue and fade frames go through accept, prepare, a one-bit-per-cycle divider over a
// 28+FRAC_BITS bit numerator, and commit; other frames skip the divider.
// One transaction is in flight; a new one is accepted while the last response waits.
// Reset is synchronous and restores register and effect defaults at once.
// A stalled response holds the next frame in its final step until taken.
module rgb_led_animation_sequencer
   import rgbs_pkg::*;
#(
   parameter int TABLE_COLORS = 7,
   parameter int FRAC_BITS    = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [DT_W-1:0]      req_dt_us,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_red_level,
   output logic [7:0]           rsp_green_level,
   output logic [7:0]           rsp_blue_level,
   output logic [1:0]           rsp_effect_now,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   rgbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rgbs_datapath #(.TABLE_COLORS(TABLE_COLORS), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_dt_us   (req_dt_us),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .red_level   (rsp_red_level),
      .green_level (rsp_green_level),
      .blue_level  (rsp_blue_level),
      .effect_now  (rsp_effect_now)
   );

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while a frame is in progress");

   a_apply_free: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> (!rsp_valid || rsp_ready))
      else $error("frame committed over an unread response");

   a_apply_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> rsp_valid)
      else $error("committed frame without response");

   a_start_not_apply: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !cmd.apply)
      else $error("frame committed before divide finished");

endmodule

>>> rtl/core/rgbs_div.sv
// Restoring divider, one quotient bit per cycle.
module rgbs_div #(
   parameter int NUM_W = 44,
   parameter int DEN_W = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   shifted;
   logic             ge;

   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign ge      = (shifted >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         quo_in  = numer;
         rem_in  = '0;
         den_in  = denom;
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(shifted - {1'b0, den_ff}) : shifted[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = busy_ff && (cnt_ff == CNT_W'(1));
   assign quot = quo_ff;

endmodule

>>> rtl/core/rgbs_datapath.sv
// Effect state, configuration registers and frame step logic.
module rgbs_datapath
   import rgbs_pkg::*;
#(
   parameter int TABLE_COLORS = 7,
   parameter int FRAC_BITS    = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic [DT_W-1:0]      req_dt_us,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output logic [7:0]           red_level,
   output logic [7:0]           green_level,
   output logic [7:0]           blue_level,
   output logic [1:0]           effect_now
);

   localparam int LW    = 8 + FRAC_BITS;
   localparam int DW    = LW + 1;
   localparam int NUM_W = 28 + FRAC_BITS;
   localparam int IDX_W = $clog2(TABLE_COLORS);
   localparam logic [LW-1:0] LEVEL_MAX = {8'hFF, {FRAC_BITS{1'b0}}};
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_COLORS - 1);
   // reciprocal of the table size, exact for any 16-bit dividend
   localparam logic [32:0] RCP = 33'((64'd1 << 32) / TABLE_COLORS + 1);

   logic [CFG_W-1:0] shift_period_ff, hue_sweep_ff, strobe_half_ff;
   logic [CFG_W-1:0] fade_sweep_ff, color_step_ff;
   logic             color_random_ff;

   logic [DT_W-1:0]  dt_ff;
   logic [1:0]       effect_ff, effect_in;
   logic [ACC_W-1:0] shift_acc_ff, shift_acc_in;
   logic [23:0]      rgb_ff, rgb_in;
   logic [LW-1:0]    hue_lvl_ff, hue_lvl_in;
   logic [1:0]       hue_ph_ff, hue_ph_in;
   logic [LW-1:0]    fade_lvl_ff, fade_lvl_in;
   logic             fade_up_ff, fade_up_in;
   logic             strobe_on_ff, strobe_on_in;
   logic [ACC_W-1:0] strobe_acc_ff, strobe_acc_in;
   logic [ACC_W-1:0] table_acc_ff, table_acc_in;
   logic [IDX_W-1:0] table_pos_ff, table_pos_in;
   logic [15:0]      lfsr_ff, lfsr_in;
   logic [IDX_W-1:0] pick_ff, pick_in;

   logic [15:0]      lfsr_nx;
   logic [48:0]      rcp_prod;
   logic [16:0]      rcp_quo;
   logic [15:0]      rcp_rem;
   logic [27:0]      dt_mul;
   logic [CFG_W-1:0] sweep;
   logic [NUM_W-1:0] div_num;
   logic [CFG_W-1:0] div_den;
   logic             div_done;
   logic [NUM_W-1:0] quot;
   logic [DW-1:0]    delta;
   timer_type        strobe_t, table_t, shift_t;

   logic [DW:0]      hue_sum;
   logic             hue_wrap;
   logic [LW-1:0]    hue_new, hue_fall;
   logic [1:0]       ph_new;
   logic [LW-1:0]    fade_room;
   logic [LW-1:0]    fade_new;
   logic [IDX_W-1:0] nxt0, nxt;
   logic [7:0]       rise, fall, fl;

   assign lfsr_nx = lfsr_advance(lfsr_ff);
   assign dt_mul  = {dt_ff, 8'd0} - 28'(dt_ff);
   assign sweep   = (effect_ff == EFF_FADE) ? fade_sweep_ff : hue_sweep_ff;
   assign div_num = {dt_mul, {FRAC_BITS{1'b0}}};
   assign div_den = (sweep == '0) ? CFG_W'(1) : sweep;

   // Random pick: next LFSR word modulo the table size, registered ahead of the commit.
   // The LFSR only moves at a commit, so the pick is settled by then.
   assign rcp_prod = {33'd0, lfsr_nx} * {16'd0, RCP};
   assign rcp_quo  = rcp_prod[48:32];
   assign rcp_rem  = lfsr_nx - 16'(rcp_quo * 17'(TABLE_COLORS));
   assign pick_in  = rcp_rem[IDX_W-1:0];

   rgbs_div #(.NUM_W(NUM_W), .DEN_W(CFG_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (div_num),
      .denom (div_den),
      .done  (div_done),
      .quot  (quot)
   );

   // Saturate the increment; anything above full scale behaves the same.
   assign delta = (|quot[NUM_W-1:DW]) ? {DW{1'b1}} : quot[DW-1:0];

   assign strobe_t = timer_step(strobe_acc_ff, dt_ff, strobe_half_ff);
   assign table_t  = timer_step(table_acc_ff, dt_ff, color_step_ff);
   assign shift_t  = timer_step(shift_acc_ff, dt_ff, shift_period_ff);

   assign status.ramp     = (effect_ff == EFF_HUE) || (effect_ff == EFF_FADE);
   assign status.div_done = div_done;

   // Hue step
   assign hue_sum  = {2'b00, hue_lvl_ff} + (DW+1)'(delta);
   assign hue_wrap = (hue_sum > (DW+1)'(LEVEL_MAX));
   assign hue_new  = hue_wrap ? '0 : hue_sum[LW-1:0];
   assign hue_fall = LEVEL_MAX - hue_new;
   assign rise     = hue_new[LW-1:FRAC_BITS];
   assign fall     = hue_fall[LW-1:FRAC_BITS];
   always_comb begin
      ph_new = hue_ph_ff;
      if (hue_wrap) begin
         ph_new = (hue_ph_ff == 2'd2) ? 2'd0 : ((hue_ph_ff == 2'd3) ? 2'd1 : hue_ph_ff + 2'd1);
      end
   end

   // Fade step
   assign fade_room = LEVEL_MAX - fade_lvl_ff;
   always_comb begin
      if (fade_up_ff) begin
         fade_new = (delta >= DW'(fade_room)) ? LEVEL_MAX : LW'(DW'(fade_lvl_ff) + delta);
      end else begin
         fade_new = (delta >= DW'(fade_lvl_ff)) ? '0 : LW'(DW'(fade_lvl_ff) - delta);
      end
   end
   assign fl = fade_new[LW-1:FRAC_BITS];

   // Table pick
   always_comb begin
      if (color_random_ff) begin
         nxt0 = pick_ff;
      end else begin
         nxt0 = (table_pos_ff == LAST_IDX) ? '0 : table_pos_ff + 1'b1;
      end
      nxt = nxt0;
      if (nxt0 == table_pos_ff) begin
         nxt = (nxt0 == LAST_IDX) ? '0 : nxt0 + 1'b1;
      end
   end

   always_comb begin
      effect_in     = effect_ff;
      shift_acc_in  = shift_acc_ff;
      rgb_in        = rgb_ff;
      hue_lvl_in    = hue_lvl_ff;
      hue_ph_in     = hue_ph_ff;
      fade_lvl_in   = fade_lvl_ff;
      fade_up_in    = fade_up_ff;
      strobe_on_in  = strobe_on_ff;
      strobe_acc_in = strobe_acc_ff;
      table_acc_in  = table_acc_ff;
      table_pos_in  = table_pos_ff;
      lfsr_in       = lfsr_ff;
      if (cmd.apply) begin
         unique case (effect_ff)
            EFF_HUE: begin
               hue_lvl_in = hue_new;
               hue_ph_in  = ph_new;
               unique case (ph_new)
                  2'd0: rgb_in = {rise, 8'd0, fall};
                  2'd1: rgb_in = {fall, rise, 8'd0};
                  2'd2: rgb_in = {8'd0, fall, rise};
                  default: rgb_in = 24'd0;
               endcase
            end
            EFF_STROBE: begin
               strobe_acc_in = strobe_t.acc;
               if (strobe_t.hit) begin
                  strobe_on_in = !strobe_on_ff;
                  rgb_in       = strobe_on_ff ? 24'd0 : 24'hFFFFFF;
               end
            end
            EFF_FADE: begin
               fade_lvl_in = fade_new;
               if (fade_new == '0) begin
                  fade_up_in = 1'b1;
               end else if (fade_new == LEVEL_MAX) begin
                  fade_up_in = 1'b0;
               end
               rgb_in = {fl, fl, fl};
            end
            default: begin
               table_acc_in = table_t.acc;
               if (table_t.hit) begin
                  if (color_random_ff) begin
                     lfsr_in = lfsr_nx;
                  end
                  table_pos_in = nxt;
                  rgb_in       = palette(4'(nxt));
               end
            end
         endcase
         shift_acc_in = shift_t.acc;
         if (shift_t.hit) begin
            effect_in = effect_ff + 2'd1;
            unique case (effect_in)
               EFF_HUE: begin
                  rgb_in     = 24'h0000FF;
                  hue_lvl_in = '0;
                  hue_ph_in  = 2'd0;
               end
               EFF_STROBE: begin
                  rgb_in        = 24'd0;
                  strobe_on_in  = 1'b0;
                  strobe_acc_in = '0;
               end
               EFF_FADE: begin
                  rgb_in      = 24'd0;
                  fade_lvl_in = '0;
                  fade_up_in  = 1'b1;
               end
               default: begin
                  table_pos_in = '0;
                  table_acc_in = '0;
                  rgb_in       = palette(4'd0);
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_period_ff <= RST_SHIFT_PERIOD;
         hue_sweep_ff    <= RST_HUE_SWEEP;
         strobe_half_ff  <= RST_STROBE_HALF;
         fade_sweep_ff   <= RST_FADE_SWEEP;
         color_step_ff   <= RST_COLOR_STEP;
         color_random_ff <= 1'b1;
         effect_ff       <= EFF_HUE;
         shift_acc_ff    <= '0;
         rgb_ff          <= 24'h0000FF;
         hue_lvl_ff      <= '0;
         hue_ph_ff       <= 2'd0;
         fade_lvl_ff     <= '0;
         fade_up_ff      <= 1'b1;
         strobe_on_ff    <= 1'b0;
         strobe_acc_ff   <= '0;
         table_acc_ff    <= '0;
         table_pos_ff    <= '0;
         lfsr_ff         <= LFSR_SEED;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_SHIFT_PERIOD: shift_period_ff <= csr_wdata;
               CSR_HUE_SWEEP:    hue_sweep_ff    <= csr_wdata;
               CSR_STROBE_HALF:  strobe_half_ff  <= csr_wdata;
               CSR_FADE_SWEEP:   fade_sweep_ff   <= csr_wdata;
               CSR_COLOR_STEP:   color_step_ff   <= csr_wdata;
               CSR_COLOR_RANDOM: color_random_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         effect_ff     <= effect_in;
         shift_acc_ff  <= shift_acc_in;
         rgb_ff        <= rgb_in;
         hue_lvl_ff    <= hue_lvl_in;
         hue_ph_ff     <= hue_ph_in;
         fade_lvl_ff   <= fade_lvl_in;
         fade_up_ff    <= fade_up_in;
         strobe_on_ff  <= strobe_on_in;
         strobe_acc_ff <= strobe_acc_in;
         table_acc_ff  <= table_acc_in;
         table_pos_ff  <= table_pos_in;
         lfsr_ff       <= lfsr_in;
      end
      pick_ff <= pick_in;
      if (cmd.take) begin
         dt_ff <= req_dt_us;
      end
   end

   assign red_level   = rgb_ff[23:16];
   assign green_level = rgb_ff[15:8];
   assign blue_level  = rgb_ff[7:0];
   assign effect_now  = effect_ff;

endmodule

>>> rtl/core/rgbs_ctrl.sv
// Frame sequencing state machine and response handshake.
module rgbs_ctrl
   import rgbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_PREP  = 2'd1;
   localparam logic [1:0] S_DIV   = 2'd2;
   localparam logic [1:0] S_APPLY = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd           = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            if (status.ramp) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_APPLY;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_APPLY;
            end
         end
         default: begin
            // hold the step until the previous transaction has left
            if (out_free) begin
               cmd.apply    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> tb/sv/tb_rgb_led_animation_sequencer.sv
// Self-checking testbench for the RGB LED animation sequencer.
module tb_rgb_led_animation_sequencer;
   import rgbs_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_NONE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_NONE_HI = 3'd7;
   localparam bit [63:0] LEVEL_FULL = 64'd255 << 16;
   localparam bit [63:0] COUNT_SAT  = 64'h1FFFFFF;
   localparam int SETTLE_CYCLES = 100;

   typedef struct {
      bit [7:0] red;
      bit [7:0] green;
      bit [7:0] blue;
      bit [1:0] effect;
   } frame_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [DT_W-1:0] req_dt_us = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [7:0] rsp_red_level, rsp_green_level, rsp_blue_level;
   logic [1:0] rsp_effect_now;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   rgb_led_animation_sequencer dut (.*);

   always #5 clock = ~clock;

   // register copy
   bit [23:0] shift_period, hue_sweep, strobe_half, fade_sweep, color_step;
   bit        color_random;
   // sequencer state copy
   bit [1:0]  eff;
   bit [63:0] shift_count, hue_lvl, fade_lvl, strobe_count, table_count;
   bit [1:0]  hue_ph;
   bit        fade_rising, strobe_lit;
   bit [2:0]  table_idx;
   bit [15:0] lfsr;
   bit [7:0]  out_r, out_g, out_b;
   bit [23:0] colors [7] = '{24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                             24'hFFFF00, 24'h00FFFF, 24'hFF00FF};

   bit [DT_W-1:0] pending_ticks [$];
   frame_type     expected_frames [$];
   int  errors = 0, frames_checked = 0, csr_writes = 0;
   int  tick_gap = 0, stall_left = 0;
   bit  quiet = 0;
   bit  [3:0] effects_seen = 0;
   bit  launch;
   bit  [DT_W-1:0] next_dt;

   function automatic bit [63:0] ramp_step(bit [19:0] dt, bit [23:0] sweep);
      bit [63:0] d;
      d = (sweep == 0) ? 64'd1 : 64'(sweep);
      return ((64'(dt) * 64'd255) << 16) / d;
   endfunction

   function automatic bit timer_cross(inout bit [63:0] acc, input bit [19:0] dt,
                                      input bit [23:0] period);
      bit hit;
      acc = acc + 64'(dt);
      hit = (acc >= 64'(period));
      if (hit) acc = acc - 64'(period);
      if (acc > COUNT_SAT) acc = COUNT_SAT;
      return hit;
   endfunction

   task automatic show_color();
      {out_r, out_g, out_b} = colors[table_idx % 7];
   endtask

   task automatic predict_frame(input bit [19:0] dt);
      frame_type f;
      bit [63:0] v, d;
      bit [7:0]  rise, fall, lv;
      bit [2:0]  nxt;
      case (eff)
         EFF_HUE: begin
            v = hue_lvl + ramp_step(dt, hue_sweep);
            if (v > LEVEL_FULL) begin
               hue_ph = 2'((hue_ph + 1) % 3);
               v = 0;
            end
            hue_lvl = v;
            rise = 8'(v >> 16);
            fall = 8'((LEVEL_FULL - v) >> 16);
            case (hue_ph)
               2'd0: {out_r, out_g, out_b} = {rise, 8'd0, fall};
               2'd1: {out_r, out_g, out_b} = {fall, rise, 8'd0};
               2'd2: {out_r, out_g, out_b} = {8'd0, fall, rise};
               default: {out_r, out_g, out_b} = 24'd0;
            endcase
         end
         EFF_STROBE: begin
            if (timer_cross(strobe_count, dt, strobe_half)) begin
               strobe_lit = !strobe_lit;
               lv = strobe_lit ? 8'd255 : 8'd0;
               {out_r, out_g, out_b} = {lv, lv, lv};
            end
         end
         EFF_FADE: begin
            d = ramp_step(dt, fade_sweep);
            if (fade_rising)
               fade_lvl = (d >= LEVEL_FULL - fade_lvl) ? LEVEL_FULL : fade_lvl + d;
            else
               fade_lvl = (d >= fade_lvl) ? 64'd0 : fade_lvl - d;
            if (fade_lvl == 0) fade_rising = 1;
            else if (fade_lvl == LEVEL_FULL) fade_rising = 0;
            lv = 8'(fade_lvl >> 16);
            {out_r, out_g, out_b} = {lv, lv, lv};
         end
         default: begin
            if (timer_cross(table_count, dt, color_step)) begin
               if (color_random) begin
                  if (lfsr == 0) lfsr = LFSR_SEED;
                  lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
                  nxt = 3'(lfsr % 7);
               end else begin
                  nxt = 3'((table_idx + 1) % 7);
               end
               if (nxt == table_idx) nxt = 3'((nxt + 1) % 7);
               table_idx = nxt;
               show_color();
            end
         end
      endcase
      if (timer_cross(shift_count, dt, shift_period)) begin
         eff = eff + 2'd1;
         case (eff)
            EFF_HUE: begin
               {out_r, out_g, out_b} = 24'h0000FF;
               hue_lvl = 0;
               hue_ph = 0;
            end
            EFF_STROBE: begin
               {out_r, out_g, out_b} = 24'd0;
               strobe_lit = 0;
               strobe_count = 0;
            end
            EFF_FADE: begin
               {out_r, out_g, out_b} = 24'd0;
               fade_lvl = 0;
               fade_rising = 1;
            end
            default: begin
               table_idx = 0;
               table_count = 0;
               show_color();
            end
         endcase
      end
      f.red = out_r; f.green = out_g; f.blue = out_b; f.effect = eff;
      expected_frames.push_back(f);
   endtask

   // Sender: hold valid until the transaction is taken, then maybe idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         tick_gap = 0;
      end else begin
         launch = req_valid;
         if (req_valid && req_ready) begin
            predict_frame(req_dt_us);
            launch = 0;
         end
         if (!launch) begin
            if (tick_gap > 0) begin
               tick_gap--;
            end else if (pending_ticks.size() > 0) begin
               next_dt = pending_ticks.pop_front();
               req_dt_us <= next_dt;
               launch = 1;
               if (!quiet && $urandom_range(0, 3) == 0) tick_gap = $urandom_range(1, 9);
            end
         end
         req_valid <= launch;
      end
   end

   // Receiver: random stall bursts, compare each frame against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected frame r=%0d g=%0d b=%0d eff=%0d",
                  rsp_red_level, rsp_green_level, rsp_blue_level, rsp_effect_now);
            end else begin
               frame_type e;
               e = expected_frames.pop_front();
               frames_checked++;
               effects_seen[rsp_effect_now] = 1;
               if (e.red !== rsp_red_level || e.green !== rsp_green_level ||
                   e.blue !== rsp_blue_level || e.effect !== rsp_effect_now) begin
                  errors++;
                  if (errors <= 10)
                     $display("frame %0d: expected %0d/%0d/%0d eff %0d, got %0d/%0d/%0d eff %0d",
                        frames_checked, e.red, e.green, e.blue, e.effect, rsp_red_level,
                        rsp_green_level, rsp_blue_level, rsp_effect_now);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 8);
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input bit [23:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      @(posedge clock);
      csr_writes++;
      case (idx)
         CSR_SHIFT_PERIOD: shift_period = data;
         CSR_HUE_SWEEP:    hue_sweep = data;
         CSR_STROBE_HALF:  strobe_half = data;
         CSR_FADE_SWEEP:   fade_sweep = data;
         CSR_COLOR_STEP:   color_step = data;
         CSR_COLOR_RANDOM: color_random = data[0];
         default: ;
      endcase
   endtask

   task automatic write_all(input bit [23:0] sp, hs, sh, fs, cs, input bit rnd);
      write_csr(CSR_SHIFT_PERIOD, sp);
      write_csr(CSR_HUE_SWEEP, hs);
      write_csr(CSR_STROBE_HALF, sh);
      write_csr(CSR_FADE_SWEEP, fs);
      write_csr(CSR_COLOR_STEP, cs);
      write_csr(CSR_COLOR_RANDOM, {23'd0, rnd});
   endtask

   // Wait until every frame is back, then let the datapath drain.
   task automatic drain();
      while (pending_ticks.size() > 0 || req_valid || expected_frames.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic bit [23:0] pick_period(int lo, int hi);
      if ($urandom_range(0, 9) == 0) return 24'($urandom);
      return 24'($urandom_range(lo, hi));
   endfunction

   task automatic queue_random(int count, int dt_hi);
      repeat (count) begin
         if ($urandom_range(0, 19) == 0) pending_ticks.push_back(DT_W'($urandom));
         else pending_ticks.push_back(DT_W'($urandom_range(0, dt_hi)));
      end
   endtask

   initial begin
      shift_period = RST_SHIFT_PERIOD; hue_sweep = RST_HUE_SWEEP;
      strobe_half = RST_STROBE_HALF; fade_sweep = RST_FADE_SWEEP;
      color_step = RST_COLOR_STEP; color_random = 1;
      eff = EFF_HUE; shift_count = 0; hue_lvl = 0; hue_ph = 0;
      fade_lvl = 0; fade_rising = 1; strobe_lit = 0; strobe_count = 0;
      table_count = 0; table_idx = 0; lfsr = LFSR_SEED;
      {out_r, out_g, out_b} = 24'h0000FF;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // defaults: field extremes, and full-scale ticks walk through every effect
      foreach (pending_ticks[i]) ;
      pending_ticks = '{0, 1, 20'hFFFFF, 0, 20'h80000, 20'hFFFFF, 20'hFFFFF, 12345,
                        30000, 29999, 20'hFFFFF, 100000, 99999, 20'h55555, 20'hAAAAA,
                        20'hFFFFF, 7, 500000, 20'hFFFFF, 20'hFFFFF, 0, 1};
      drain();

      // every register at its minimum: effect switches on every tick
      write_all(24'd1, 24'd1, 24'd1, 24'd1, 24'd1, 1'b0);
      queue_random(40, 20'hFFFFF);
      drain();
      // every register at its maximum
      write_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
      queue_random(60, 20'hFFFFF);
      drain();
      // zero sweeps count as one; zero shift period switches every tick
      write_all(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b1);
      write_csr(CSR_NONE_LO, 24'd77);
      write_csr(CSR_NONE_HI, 24'hFFFFFF);
      queue_random(30, 20'hFFFF);
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         if (ph == 9) quiet = 1;
         write_all(pick_period(20000, 400000), pick_period(1000, 200000),
                   pick_period(100, 50000), pick_period(1000, 200000),
                   pick_period(100, 50000), 1'($urandom));
         queue_random(120, $urandom_range(100, 20000));
         drain();
      end

      $display("checked %0d frames over %0d register writes, effects seen mask %b",
               frames_checked, csr_writes, effects_seen);
      if (errors == 0 && expected_frames.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", errors);
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d frames outstanding", expected_frames.size());
      $display("simulation failed");
      $finish;
   end

endmodule
